// ===== rtl/rvdhf_pkg.sv =====
// ----------------------------------------------------------------------------
// rvdhf_pkg
// Types, opcode and operation codes shared by the RV32 decode/hazard block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvdhf_pkg;

	// Major opcodes
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;

	// funct7 groups of register-register ops
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	// Upper immediate mask
	localparam logic [31:0] UIMM_MASK = 32'hFFFFF000;

	// Dense operation numbers
	localparam logic [5:0] OP_ADD   = 6'd0;
	localparam logic [5:0] OP_SUB   = 6'd1;
	localparam logic [5:0] OP_SLL   = 6'd2;
	localparam logic [5:0] OP_SLT   = 6'd3;
	localparam logic [5:0] OP_SRA   = 6'd4;
	localparam logic [5:0] OP_DIV   = 6'd5;
	localparam logic [5:0] OP_XOR   = 6'd6;
	localparam logic [5:0] OP_SRL   = 6'd7;
	localparam logic [5:0] OP_OR    = 6'd8;
	localparam logic [5:0] OP_AND   = 6'd9;
	localparam logic [5:0] OP_MUL   = 6'd10;
	localparam logic [5:0] OP_REM   = 6'd11;
	localparam logic [5:0] OP_ADDI  = 6'd12;
	localparam logic [5:0] OP_SLTI  = 6'd13;
	localparam logic [5:0] OP_XORI  = 6'd14;
	localparam logic [5:0] OP_ORI   = 6'd15;
	localparam logic [5:0] OP_ANDI  = 6'd16;
	localparam logic [5:0] OP_LW    = 6'd17;
	localparam logic [5:0] OP_LB    = 6'd18;
	localparam logic [5:0] OP_LH    = 6'd19;
	localparam logic [5:0] OP_LD    = 6'd20;
	localparam logic [5:0] OP_JALR  = 6'd21;
	localparam logic [5:0] OP_SB    = 6'd22;
	localparam logic [5:0] OP_SH    = 6'd23;
	localparam logic [5:0] OP_SW    = 6'd24;
	localparam logic [5:0] OP_SD    = 6'd25;
	localparam logic [5:0] OP_BEQ   = 6'd26;
	localparam logic [5:0] OP_BNE   = 6'd27;
	localparam logic [5:0] OP_BLT   = 6'd28;
	localparam logic [5:0] OP_BGE   = 6'd29;
	localparam logic [5:0] OP_AUIPC = 6'd30;
	localparam logic [5:0] OP_LUI   = 6'd31;
	localparam logic [5:0] OP_JAL   = 6'd32;

	// Instruction formats
	localparam logic [2:0] KIND_R = 3'd0;
	localparam logic [2:0] KIND_I = 3'd1;
	localparam logic [2:0] KIND_S = 3'd2;
	localparam logic [2:0] KIND_B = 3'd3;
	localparam logic [2:0] KIND_U = 3'd4;
	localparam logic [2:0] KIND_J = 3'd5;

	// Operand source selects
	localparam logic [1:0] FWD_RF  = 2'd0;
	localparam logic [1:0] FWD_EX  = 2'd1;
	localparam logic [1:0] FWD_MEM = 2'd2;

	// Input beat
	typedef struct packed {
		logic [31:0] instr_word;
		logic        ex_writes;
		logic [4:0]  ex_rd;
		logic        ex_is_load;
		logic        mem_writes;
		logic [4:0]  mem_rd;
	} instr_beat_t;

	// Result beat
	typedef struct packed {
		logic               known;
		logic [5:0]         op_code;
		logic [4:0]         dest_reg;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic signed [31:0] immediate;
		logic               writes_dest;
		logic               is_load_op;
		logic               stall_res;
		logic [1:0]         fwd_a;
		logic [1:0]         fwd_b;
		logic               store_fwd;
	} dec_beat_t;

	// Decoder facts handed to the hazard unit
	typedef struct packed {
		logic       known;
		logic       rd_ex1;     // rs1 read in EX
		logic       rd_ex2;     // rs2 read in EX
		logic       is_store;
		logic [4:0] src1;
		logic [4:0] src2;
	} dec_info_t;

	// Hazard unit verdict
	typedef struct packed {
		logic       stall;
		logic [1:0] fwd_a;
		logic [1:0] fwd_b;
		logic       store_fwd;
	} hz_info_t;

endpackage

// ===== rtl/rvdhf_decode.sv =====
// ----------------------------------------------------------------------------
// rvdhf_decode
// Instruction field decode: operation number, registers and immediate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvdhf_decode import rvdhf_pkg::*; (
	input  logic [31:0]        instr_word,
	output logic               known,
	output logic [5:0]         op_code,
	output logic [4:0]         dest_reg,
	output logic signed [31:0] immediate,
	output logic               writes_dest,
	output logic               is_load_op,
	output dec_info_t          info
);

	logic [6:0] opc;
	logic [4:0] rd;
	logic [2:0] f3;
	logic [4:0] rs1;
	logic [4:0] rs2;
	logic [6:0] f7;
	logic [2:0] kind;
	logic       hit;
	logic [5:0] op;
	logic [31:0] imm;
	logic       has1;
	logic       has2;
	logic       ex2;
	logic       wr;

	assign opc = instr_word[6:0];
	assign rd  = instr_word[11:7];
	assign f3  = instr_word[14:12];
	assign rs1 = instr_word[19:15];
	assign rs2 = instr_word[24:20];
	assign f7  = instr_word[31:25];

	// Map opcode and function bits to a dense operation number
	always_comb begin
		hit  = 1'b0;
		op   = OP_ADD;
		kind = KIND_R;
		case (opc)
			OPC_OP: begin
				kind = KIND_R;
				case (f7)
					F7_BASE: begin
						hit = 1'b1;
						case (f3)
							3'd0: op = OP_ADD;
							3'd1: op = OP_SLL;
							3'd2: op = OP_SLT;
							3'd4: op = OP_XOR;
							3'd5: op = OP_SRL;
							3'd6: op = OP_OR;
							3'd7: op = OP_AND;
							default: hit = 1'b0;
						endcase
					end
					F7_ALT: begin
						hit = 1'b1;
						case (f3)
							3'd0: op = OP_SUB;
							3'd5: op = OP_SRA;
							default: hit = 1'b0;
						endcase
					end
					F7_MULDIV: begin
						hit = 1'b1;
						case (f3)
							3'd0: op = OP_MUL;
							3'd4: op = OP_DIV;
							3'd6: op = OP_REM;
							default: hit = 1'b0;
						endcase
					end
					default: hit = 1'b0;
				endcase
			end
			OPC_OPIMM: begin
				kind = KIND_I;
				hit  = 1'b1;
				case (f3)
					3'd0: op = OP_ADDI;
					3'd2: op = OP_SLTI;
					3'd4: op = OP_XORI;
					3'd6: op = OP_ORI;
					3'd7: op = OP_ANDI;
					default: hit = 1'b0;
				endcase
			end
			OPC_LOAD: begin
				kind = KIND_I;
				hit  = 1'b1;
				case (f3)
					3'd2: op = OP_LW;
					3'd0: op = OP_LB;
					3'd1: op = OP_LH;
					3'd3: op = OP_LD;
					default: hit = 1'b0;
				endcase
			end
			OPC_JALR: begin
				kind = KIND_I;
				hit  = (f3 == 3'd0);
				op   = OP_JALR;
			end
			OPC_STORE: begin
				kind = KIND_S;
				hit  = (f3 inside {[3'd0:3'd3]});
				op   = OP_SB + {3'b000, f3};
			end
			OPC_BRANCH: begin
				kind = KIND_B;
				hit  = 1'b1;
				case (f3)
					3'd0: op = OP_BEQ;
					3'd1: op = OP_BNE;
					3'd4: op = OP_BLT;
					3'd5: op = OP_BGE;
					default: hit = 1'b0;
				endcase
			end
			OPC_AUIPC: begin
				kind = KIND_U;
				hit  = 1'b1;
				op   = OP_AUIPC;
			end
			OPC_LUI: begin
				kind = KIND_U;
				hit  = 1'b1;
				op   = OP_LUI;
			end
			OPC_JAL: begin
				kind = KIND_J;
				hit  = 1'b1;
				op   = OP_JAL;
			end
			default: hit = 1'b0;
		endcase
	end

	// Assemble the immediate for the format
	always_comb begin
		case (kind)
			KIND_I: imm = {{20{instr_word[31]}}, instr_word[31:20]};
			KIND_S: imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
			KIND_B: imm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
				instr_word[30:25], instr_word[11:8], 1'b0};
			KIND_U: imm = instr_word & UIMM_MASK;
			KIND_J: imm = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
				instr_word[20], instr_word[30:21], 1'b0};
			default: imm = 32'd0;
		endcase
	end

	// Which register fields the format actually uses
	assign has1 = hit && (kind == KIND_R || kind == KIND_I || kind == KIND_S || kind == KIND_B);
	assign has2 = hit && (kind == KIND_R || kind == KIND_S || kind == KIND_B);
	assign ex2  = hit && (kind == KIND_R || kind == KIND_B);
	assign wr   = hit && (kind == KIND_R || kind == KIND_I || kind == KIND_U || kind == KIND_J);

	// Drive results, all zero for an unknown word
	assign known       = hit;
	assign op_code     = hit ? op : 6'd0;
	assign dest_reg    = wr ? rd : 5'd0;
	assign immediate   = hit ? $signed(imm) : 32'sd0;
	assign writes_dest = wr;
	assign is_load_op  = hit && (op == OP_LW || op == OP_LB || op == OP_LH);

	assign info.known    = hit;
	assign info.rd_ex1   = has1;
	assign info.rd_ex2   = ex2;
	assign info.is_store = hit && (kind == KIND_S);
	assign info.src1     = has1 ? rs1 : 5'd0;
	assign info.src2     = has2 ? rs2 : 5'd0;

endmodule

// ===== rtl/rvdhf_hazard.sv =====
// ----------------------------------------------------------------------------
// rvdhf_hazard
// Load-use stall detection and operand forwarding selects.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvdhf_hazard import rvdhf_pkg::*; (
	input  dec_info_t  info,
	input  logic       ex_writes,
	input  logic [4:0] ex_rd,
	input  logic       ex_is_load,
	input  logic       mem_writes,
	input  logic [4:0] mem_rd,
	output hz_info_t   hz
);

	// EX match wins over MEM; x0 never matches
	function automatic logic [1:0] fwd_sel(
		input logic [4:0] r,
		input logic       exw,
		input logic [4:0] exrd,
		input logic       memw,
		input logic [4:0] memrd
	);
		logic [1:0] sel;
		sel = FWD_RF;
		if (r != 5'd0) begin
			if (exw && exrd == r) sel = FWD_EX;
			else if (memw && memrd == r) sel = FWD_MEM;
		end
		return sel;
	endfunction

	logic stall;
	logic hit1;
	logic hit2;

	// Stall when a load in EX feeds a source read in EX
	assign hit1  = info.rd_ex1 && (info.src1 == ex_rd);
	assign hit2  = info.rd_ex2 && (info.src2 == ex_rd);
	assign stall = info.known && ex_writes && ex_is_load && (ex_rd != 5'd0) && (hit1 || hit2);

	// Drop forwards during a stall
	assign hz.stall = stall;
	assign hz.fwd_a = (!stall && info.rd_ex1) ?
		fwd_sel(info.src1, ex_writes, ex_rd, mem_writes, mem_rd) : FWD_RF;
	assign hz.fwd_b = (!stall && info.rd_ex2) ?
		fwd_sel(info.src2, ex_writes, ex_rd, mem_writes, mem_rd) : FWD_RF;
	assign hz.store_fwd = !stall && info.is_store && (info.src2 != 5'd0) &&
		ex_writes && (ex_rd == info.src2);

endmodule

// ===== rtl/rv32_decode_hazard_forward.sv =====
// ----------------------------------------------------------------------------
// rv32_decode_hazard_forward
// RV32 decode stage with load-use stall detection and forwarding selects.
// ----------------------------------------------------------------------------
//  channel   valid        stall        beat        width
//  instr     instr_valid  instr_stall  instr_beat  instr_beat_t, into block
//  dec       dec_valid    dec_stall    dec_beat    dec_beat_t, out of block
//
//  The input register captures each accepted instr beat, then decode and
//  hazard logic feed the result register, which drives dec_valid.
//  One beat per cycle is sustained while dec_stall is low; both registers
//  advance together. A stall on dec holds the result register and, once the
//  input register also holds a beat, raises instr_stall in the same cycle.
//  Reset clears both valid flags; no beat is lost or repeated across a stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32_decode_hazard_forward import rvdhf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_stall,
	input  instr_beat_t instr_beat,
	output logic        dec_valid,
	input  logic        dec_stall,
	output dec_beat_t   dec_beat
);

	instr_beat_t beat_s1;
	logic        vld_s1;
	dec_beat_t   beat_s2;
	logic        vld_s2;
	logic        adv_s2;
	logic        take_s1;
	dec_beat_t   res;
	dec_info_t   info;
	hz_info_t    hz;

	// Pipeline control
	assign adv_s2      = !vld_s2 || !dec_stall;
	assign instr_stall = vld_s1 && !adv_s2;
	assign take_s1     = instr_valid && !instr_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s2 || !vld_s1) vld_s1 <= instr_valid;
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (take_s1) beat_s1 <= instr_beat;
	end

	rvdhf_decode u_decode (
		.instr_word  (beat_s1.instr_word),
		.known       (res.known),
		.op_code     (res.op_code),
		.dest_reg    (res.dest_reg),
		.immediate   (res.immediate),
		.writes_dest (res.writes_dest),
		.is_load_op  (res.is_load_op),
		.info        (info)
	);

	rvdhf_hazard u_hazard (
		.info       (info),
		.ex_writes  (beat_s1.ex_writes),
		.ex_rd      (beat_s1.ex_rd),
		.ex_is_load (beat_s1.ex_is_load),
		.mem_writes (beat_s1.mem_writes),
		.mem_rd     (beat_s1.mem_rd),
		.hz         (hz)
	);

	assign res.src1_reg  = info.src1;
	assign res.src2_reg  = info.src2;
	assign res.stall_res = hz.stall;
	assign res.fwd_a     = hz.fwd_a;
	assign res.fwd_b     = hz.fwd_b;
	assign res.store_fwd = hz.store_fwd;

	// Load the result register
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) beat_s2 <= res;
	end

	assign dec_valid = vld_s2;
	assign dec_beat  = beat_s2;

endmodule

// ===== rtl/rvdhf_checker.sv =====
// ----------------------------------------------------------------------------
// rvdhf_checker
// Port-level checks on the decode/hazard block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvdhf_checker import rvdhf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        instr_valid,
	input logic        instr_stall,
	input instr_beat_t instr_beat,
	input logic        dec_valid,
	input logic        dec_stall,
	input dec_beat_t   dec_beat
);

	// A stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		instr_valid && instr_stall |=> instr_valid && $stable(instr_beat))
		else $error("instr beat changed under stall");

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_stall |=> dec_valid && $stable(dec_beat))
		else $error("dec beat changed under stall");

	// A load-use stall carries no forwards
	a_stall_nofwd: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_beat.stall_res |->
			dec_beat.fwd_a == FWD_RF && dec_beat.fwd_b == FWD_RF && !dec_beat.store_fwd)
		else $error("forward select during stall");

	// An unknown word gives an all-zero result
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec_beat.known |-> dec_beat == '0)
		else $error("unknown word with nonzero fields");

	// Register x0 never forwards
	a_x0_nofwd: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && (dec_beat.fwd_a != FWD_RF || dec_beat.store_fwd ||
			dec_beat.fwd_b != FWD_RF) |->
			(dec_beat.fwd_a == FWD_RF || dec_beat.src1_reg != 5'd0) &&
			(dec_beat.fwd_b == FWD_RF || dec_beat.src2_reg != 5'd0) &&
			(!dec_beat.store_fwd || dec_beat.src2_reg != 5'd0))
		else $error("forward from x0");

endmodule

bind rv32_decode_hazard_forward rvdhf_checker u_rvdhf_checker (.*);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RV32 decode, load-use stall and forwarding
// block. A directed table covers every instruction format, the extremes of
// the immediates and register fields, and the corner cases of the hazard
// logic. Random instruction words follow, mostly well-formed encodings over
// a small register pool so that EX and MEM matches are frequent. A decode
// predictor computes each expected beat that the table does not give. The
// sender runs in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import rvdhf_pkg::*;

	// funct3 encodings used by the supported instructions
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SHR  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_MUL  = 3'd0;
	localparam logic [2:0] F3_DIV  = 3'd4;
	localparam logic [2:0] F3_REM  = 3'd6;
	localparam logic [2:0] F3_BYTE = 3'd0;
	localparam logic [2:0] F3_HALF = 3'd1;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_DBL  = 3'd3;
	localparam logic [2:0] F3_JALR = 3'd0;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;

	// Receiver stall patterns
	localparam int STALL_NONE   = 0;
	localparam int STALL_LIGHT  = 1;
	localparam int STALL_HEAVY  = 2;
	localparam int STALL_PERIOD = 3;

	localparam int        RAND_ITEMS = 1025;
	localparam dec_beat_t ALL_ZERO   = '0;

	typedef struct {
		instr_beat_t beat;
		bit          has_want;
		dec_beat_t   want;
	} stim_row_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        instr_valid = 1'b0;
	logic        instr_stall;
	instr_beat_t instr_beat  = '0;
	logic        dec_valid;
	logic        dec_stall   = 1'b0;
	dec_beat_t   dec_beat;

	dec_beat_t pending_decodes[$];
	stim_row_t stim_tbl[$];
	int        mismatches = 0;
	int        burst_left = 8;

	rv32_decode_hazard_forward dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.instr_valid(instr_valid),
		.instr_stall(instr_stall),
		.instr_beat (instr_beat),
		.dec_valid  (dec_valid),
		.dec_stall  (dec_stall),
		.dec_beat   (dec_beat)
	);

	initial forever #1 clk = ~clk;

	// Pick the operand source for one register read in EX
	function automatic logic [1:0] operand_source(input logic [4:0] src, input instr_beat_t b);
		if (src == 5'd0)
			return FWD_RF;
		if (b.ex_writes && b.ex_rd == src)
			return FWD_EX;
		if (b.mem_writes && b.mem_rd == src)
			return FWD_MEM;
		return FWD_RF;
	endfunction

	// Decode one instruction beat and work out its hazard verdict
	function automatic dec_beat_t decode_predict(input instr_beat_t b);
		dec_beat_t   r;
		logic [31:0] w;
		logic [6:0]  f7;
		logic [2:0]  f3;
		logic [2:0]  fmt;
		logic [4:0]  s1;
		logic [4:0]  s2;
		logic        ok;
		logic        use1;
		logic        use2;
		logic        ex_read2;
		logic        wr;
		logic        stall;
		w   = b.instr_word;
		f7  = w[31:25];
		f3  = w[14:12];
		r   = '0;
		ok  = 1'b1;
		fmt = KIND_R;
		case (w[6:0])
		OPC_OP: begin
			fmt = KIND_R;
			case (f7)
			F7_BASE: case (f3)
				F3_ADD:  r.op_code = OP_ADD;
				F3_SLL:  r.op_code = OP_SLL;
				F3_SLT:  r.op_code = OP_SLT;
				F3_XOR:  r.op_code = OP_XOR;
				F3_SHR:  r.op_code = OP_SRL;
				F3_OR:   r.op_code = OP_OR;
				F3_AND:  r.op_code = OP_AND;
				default: ok = 1'b0;
			endcase
			F7_ALT: begin
				if (f3 == F3_ADD)
					r.op_code = OP_SUB;
				else if (f3 == F3_SHR)
					r.op_code = OP_SRA;
				else
					ok = 1'b0;
			end
			F7_MULDIV: begin
				if (f3 == F3_MUL)
					r.op_code = OP_MUL;
				else if (f3 == F3_DIV)
					r.op_code = OP_DIV;
				else if (f3 == F3_REM)
					r.op_code = OP_REM;
				else
					ok = 1'b0;
			end
			default: ok = 1'b0;
			endcase
		end
		OPC_OPIMM: begin
			fmt = KIND_I;
			case (f3)
			F3_ADD:  r.op_code = OP_ADDI;
			F3_SLT:  r.op_code = OP_SLTI;
			F3_XOR:  r.op_code = OP_XORI;
			F3_OR:   r.op_code = OP_ORI;
			F3_AND:  r.op_code = OP_ANDI;
			default: ok = 1'b0;
			endcase
		end
		OPC_LOAD: begin
			fmt = KIND_I;
			case (f3)
			F3_WORD: r.op_code = OP_LW;
			F3_BYTE: r.op_code = OP_LB;
			F3_HALF: r.op_code = OP_LH;
			F3_DBL:  r.op_code = OP_LD;
			default: ok = 1'b0;
			endcase
		end
		OPC_JALR: begin
			fmt = KIND_I;
			if (f3 == F3_JALR)
				r.op_code = OP_JALR;
			else
				ok = 1'b0;
		end
		OPC_STORE: begin
			fmt = KIND_S;
			case (f3)
			F3_BYTE: r.op_code = OP_SB;
			F3_HALF: r.op_code = OP_SH;
			F3_WORD: r.op_code = OP_SW;
			F3_DBL:  r.op_code = OP_SD;
			default: ok = 1'b0;
			endcase
		end
		OPC_BRANCH: begin
			fmt = KIND_B;
			case (f3)
			F3_BEQ:  r.op_code = OP_BEQ;
			F3_BNE:  r.op_code = OP_BNE;
			F3_BLT:  r.op_code = OP_BLT;
			F3_BGE:  r.op_code = OP_BGE;
			default: ok = 1'b0;
			endcase
		end
		OPC_AUIPC: begin
			fmt = KIND_U;
			r.op_code = OP_AUIPC;
		end
		OPC_LUI: begin
			fmt = KIND_U;
			r.op_code = OP_LUI;
		end
		OPC_JAL: begin
			fmt = KIND_J;
			r.op_code = OP_JAL;
		end
		default: ok = 1'b0;
		endcase

		// Unsupported encodings give an all-zero beat
		if (!ok)
			return ALL_ZERO;

		use1     = (fmt != KIND_U) && (fmt != KIND_J);
		use2     = (fmt == KIND_R) || (fmt == KIND_S) || (fmt == KIND_B);
		ex_read2 = (fmt == KIND_R) || (fmt == KIND_B);
		wr       = (fmt != KIND_S) && (fmt != KIND_B);
		s1       = use1 ? w[19:15] : 5'd0;
		s2       = use2 ? w[24:20] : 5'd0;

		case (fmt)
		KIND_I:  r.immediate = {{20{w[31]}}, w[31:20]};
		KIND_S:  r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
		KIND_B:  r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		KIND_U:  r.immediate = w & UIMM_MASK;
		KIND_J:  r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		default: r.immediate = '0;
		endcase

		// Load-use hazard only on sources read in EX; store data waits for MEM
		stall = b.ex_writes && b.ex_is_load && b.ex_rd != 5'd0 &&
			((use1 && s1 == b.ex_rd) || (ex_read2 && s2 == b.ex_rd));

		r.known       = 1'b1;
		r.dest_reg    = wr ? w[11:7] : 5'd0;
		r.src1_reg    = s1;
		r.src2_reg    = s2;
		r.writes_dest = wr;
		r.is_load_op  = (r.op_code == OP_LW) || (r.op_code == OP_LB) || (r.op_code == OP_LH);
		r.stall_res   = stall;
		if (!stall) begin
			if (use1)
				r.fwd_a = operand_source(s1, b);
			if (ex_read2)
				r.fwd_b = operand_source(s2, b);
			r.store_fwd = (fmt == KIND_S) && s2 != 5'd0 && b.ex_writes && b.ex_rd == s2;
		end
		return r;
	endfunction

	// Force the opcode and function bits of a raw word to encode one operation
	function automatic logic [31:0] shape_word(input logic [31:0] raw, input logic [5:0] op);
		logic [6:0] f7;
		logic [6:0] opc;
		logic [2:0] f3;
		f7 = raw[31:25];
		f3 = raw[14:12];
		case (op)
		OP_ADD:   {f7, f3, opc} = {F7_BASE, F3_ADD, OPC_OP};
		OP_SUB:   {f7, f3, opc} = {F7_ALT, F3_ADD, OPC_OP};
		OP_SLL:   {f7, f3, opc} = {F7_BASE, F3_SLL, OPC_OP};
		OP_SLT:   {f7, f3, opc} = {F7_BASE, F3_SLT, OPC_OP};
		OP_SRA:   {f7, f3, opc} = {F7_ALT, F3_SHR, OPC_OP};
		OP_DIV:   {f7, f3, opc} = {F7_MULDIV, F3_DIV, OPC_OP};
		OP_XOR:   {f7, f3, opc} = {F7_BASE, F3_XOR, OPC_OP};
		OP_SRL:   {f7, f3, opc} = {F7_BASE, F3_SHR, OPC_OP};
		OP_OR:    {f7, f3, opc} = {F7_BASE, F3_OR, OPC_OP};
		OP_AND:   {f7, f3, opc} = {F7_BASE, F3_AND, OPC_OP};
		OP_MUL:   {f7, f3, opc} = {F7_MULDIV, F3_MUL, OPC_OP};
		OP_REM:   {f7, f3, opc} = {F7_MULDIV, F3_REM, OPC_OP};
		OP_ADDI:  {f3, opc} = {F3_ADD, OPC_OPIMM};
		OP_SLTI:  {f3, opc} = {F3_SLT, OPC_OPIMM};
		OP_XORI:  {f3, opc} = {F3_XOR, OPC_OPIMM};
		OP_ORI:   {f3, opc} = {F3_OR, OPC_OPIMM};
		OP_ANDI:  {f3, opc} = {F3_AND, OPC_OPIMM};
		OP_LW:    {f3, opc} = {F3_WORD, OPC_LOAD};
		OP_LB:    {f3, opc} = {F3_BYTE, OPC_LOAD};
		OP_LH:    {f3, opc} = {F3_HALF, OPC_LOAD};
		OP_LD:    {f3, opc} = {F3_DBL, OPC_LOAD};
		OP_JALR:  {f3, opc} = {F3_JALR, OPC_JALR};
		OP_SB:    {f3, opc} = {F3_BYTE, OPC_STORE};
		OP_SH:    {f3, opc} = {F3_HALF, OPC_STORE};
		OP_SW:    {f3, opc} = {F3_WORD, OPC_STORE};
		OP_SD:    {f3, opc} = {F3_DBL, OPC_STORE};
		OP_BEQ:   {f3, opc} = {F3_BEQ, OPC_BRANCH};
		OP_BNE:   {f3, opc} = {F3_BNE, OPC_BRANCH};
		OP_BLT:   {f3, opc} = {F3_BLT, OPC_BRANCH};
		OP_BGE:   {f3, opc} = {F3_BGE, OPC_BRANCH};
		OP_AUIPC: opc = OPC_AUIPC;
		OP_LUI:   opc = OPC_LUI;
		default:  opc = OPC_JAL;
		endcase
		return {f7, raw[24:15], f3, raw[11:7], opc};
	endfunction

	// Mostly well-formed instructions over a small register pool, some noise
	function automatic instr_beat_t random_instr();
		instr_beat_t b;
		logic [31:0] w;
		bit          tight;
		w     = $urandom;
		tight = ($urandom_range(0, 9) < 6);
		if ($urandom_range(0, 99) < 85) begin
			w = shape_word(w, 6'($urandom_range(0, 32)));
			if (tight) begin
				w[11:7]  = 5'($urandom_range(0, 3));
				w[19:15] = 5'($urandom_range(0, 3));
				w[24:20] = 5'($urandom_range(0, 3));
			end
		end
		b.instr_word = w;
		b.ex_writes  = ($urandom_range(0, 3) != 0);
		b.ex_rd      = tight ? 5'($urandom_range(0, 3)) : 5'($urandom);
		b.ex_is_load = 1'($urandom_range(0, 1));
		b.mem_writes = ($urandom_range(0, 3) != 0);
		b.mem_rd     = tight ? 5'($urandom_range(0, 3)) : 5'($urandom);
		return b;
	endfunction

	task automatic add_row(input logic [31:0] w, input logic [12:0] side, input bit has_want,
		input dec_beat_t want);
		stim_row_t row;
		row.beat     = {w, side};
		row.has_want = has_want;
		row.want     = want;
		stim_tbl.insert(stim_tbl.size(), row);
	endtask

	// Present one beat, hold it until accepted, then rest at burst ends
	task automatic issue_instr(input instr_beat_t beat, input dec_beat_t want);
		instr_valid <= 1'b1;
		instr_beat  <= beat;
		do @(posedge clk); while (instr_stall);
		pending_decodes.insert(pending_decodes.size(), want);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			instr_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
				: $urandom_range(1, 12);
		end
	endtask

	// Drop valid and hold until every issued beat has been decoded
	task automatic wait_all_decoded();
		instr_valid <= 1'b0;
		do @(posedge clk); while (pending_decodes.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare each accepted result beat with the oldest pending decode
	always @(posedge clk) begin
		dec_beat_t want;
		if (arst_n && dec_valid && !dec_stall) begin
			if (pending_decodes.size() == 0) begin
				$error("dec beat arrived with no pending decode");
				mismatches++;
			end else begin
				want = pending_decodes.pop_front();
				check_field("known", 32'(want.known), 32'(dec_beat.known));
				check_field("op_code", 32'(want.op_code), 32'(dec_beat.op_code));
				check_field("dest_reg", 32'(want.dest_reg), 32'(dec_beat.dest_reg));
				check_field("src1_reg", 32'(want.src1_reg), 32'(dec_beat.src1_reg));
				check_field("src2_reg", 32'(want.src2_reg), 32'(dec_beat.src2_reg));
				check_field("immediate", want.immediate, dec_beat.immediate);
				check_field("writes_dest", 32'(want.writes_dest), 32'(dec_beat.writes_dest));
				check_field("is_load_op", 32'(want.is_load_op), 32'(dec_beat.is_load_op));
				check_field("stall_res", 32'(want.stall_res), 32'(dec_beat.stall_res));
				check_field("fwd_a", 32'(want.fwd_a), 32'(dec_beat.fwd_a));
				check_field("fwd_b", 32'(want.fwd_b), 32'(dec_beat.fwd_b));
				check_field("store_fwd", 32'(want.store_fwd), 32'(dec_beat.store_fwd));
			end
		end
	end

	// Receiver back-pressure: switch between stall patterns at random
	initial begin
		int mode;
		int span;
		int tick;
		tick = 0;
		forever begin
			mode = $urandom_range(STALL_NONE, STALL_PERIOD);
			span = $urandom_range(8, 64);
			repeat (span) begin
				@(posedge clk);
				tick++;
				case (mode)
				STALL_NONE:  dec_stall <= 1'b0;
				STALL_LIGHT: dec_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: dec_stall <= ($urandom_range(0, 3) != 0);
				default:     dec_stall <= (tick % 3 == 0);
				endcase
			end
		end
	end

	// Directed table, then random instructions
	initial begin
		instr_beat_t beat;
		dec_beat_t   lui_want;

		lui_want             = '0;
		lui_want.known       = 1'b1;
		lui_want.op_code     = OP_LUI;
		lui_want.dest_reg    = 5'd1;
		lui_want.immediate   = 32'hFFFF_F000;
		lui_want.writes_dest = 1'b1;

		// side: {ex_writes, ex_rd, ex_is_load, mem_writes, mem_rd}
		// all-zero word and all-ones word are both unsupported opcodes
		add_row(32'h0000_0000, 13'h0000, 1'b1, ALL_ZERO);
		add_row(32'hFFFF_FFFF, 13'h1FFF, 1'b1, ALL_ZERO);
		// LUI with the top immediate; no sources, so a matching load cannot stall
		add_row(32'hFFFF_F0B7, 13'h1FFF, 1'b1, lui_want);
		add_row({20'h80000, 5'd31, OPC_AUIPC}, {1'b1, 5'd31, 1'b1, 1'b1, 5'd31}, 1'b0, ALL_ZERO);
		add_row({20'hFFFFF, 5'd1, OPC_JAL}, 13'h0000, 1'b0, ALL_ZERO);
		// unsupported funct7 gives zeros even with a load-use match
		add_row({7'h7F, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_OP}, {1'b1, 5'd1, 1'b1, 1'b0, 5'd0},
			1'b1, ALL_ZERO);
		// shift-immediate is not supported
		add_row({12'h000, 5'd1, F3_SLL, 5'd1, OPC_OPIMM}, 13'h0000, 1'b1, ALL_ZERO);
		// load-use on rs1, then on rs2
		add_row({F7_BASE, 5'd7, 5'd5, F3_ADD, 5'd6, OPC_OP}, {1'b1, 5'd5, 1'b1, 1'b1, 5'd7},
			1'b0, ALL_ZERO);
		add_row({F7_ALT, 5'd5, 5'd7, F3_ADD, 5'd6, OPC_OP}, {1'b1, 5'd5, 1'b1, 1'b1, 5'd7},
			1'b0, ALL_ZERO);
		// store data from a load forwards MEM-to-MEM; store base from a load stalls
		add_row({7'h00, 5'd5, 5'd8, F3_WORD, 5'd0, OPC_STORE}, {1'b1, 5'd5, 1'b1, 1'b0, 5'd0},
			1'b0, ALL_ZERO);
		add_row({7'h00, 5'd8, 5'd5, F3_WORD, 5'd0, OPC_STORE}, {1'b1, 5'd5, 1'b1, 1'b0, 5'd0},
			1'b0, ALL_ZERO);
		// x0 never matches
		add_row({F7_BASE, 5'd0, 5'd0, F3_ADD, 5'd1, OPC_OP}, {1'b1, 5'd0, 1'b1, 1'b1, 5'd0},
			1'b0, ALL_ZERO);
		// load flag without the write flag never stalls
		add_row({7'h00, 5'd5, 5'd5, F3_BEQ, 5'd0, OPC_BRANCH}, {1'b0, 5'd5, 1'b1, 1'b1, 5'd5},
			1'b0, ALL_ZERO);
		// EX match wins over MEM match, then a MEM-only match forwards from MEM
		add_row({F7_BASE, 5'd10, 5'd9, F3_OR, 5'd1, OPC_OP}, {1'b1, 5'd9, 1'b0, 1'b1, 5'd9},
			1'b0, ALL_ZERO);
		add_row({F7_BASE, 5'd12, 5'd11, F3_AND, 5'd2, OPC_OP}, {1'b1, 5'd3, 1'b0, 1'b1, 5'd12},
			1'b0, ALL_ZERO);
		// store data matching only MEM is read from the register file
		add_row({7'h00, 5'd12, 5'd3, F3_BYTE, 5'd4, OPC_STORE}, {1'b0, 5'd0, 1'b0, 1'b1, 5'd12},
			1'b0, ALL_ZERO);
		// LD decodes but is no load for the stall check; SD with forwarded data
		add_row({12'h000, 5'd2, F3_DBL, 5'd4, OPC_LOAD}, 13'h0000, 1'b0, ALL_ZERO);
		add_row({7'h7F, 5'd4, 5'd2, F3_DBL, 5'h1F, OPC_STORE}, {1'b1, 5'd4, 1'b0, 1'b0, 5'd0},
			1'b0, ALL_ZERO);
		add_row({12'h800, 5'd31, F3_BYTE, 5'd7, OPC_LOAD}, {1'b1, 5'd31, 1'b1, 1'b0, 5'd0},
			1'b0, ALL_ZERO);
		// JALR with funct3 other than zero
		add_row({12'hFFF, 5'd1, F3_AND, 5'd1, OPC_JALR}, 13'h0000, 1'b1, ALL_ZERO);
		// branch funct3 outside BEQ/BNE/BLT/BGE
		add_row({7'h00, 5'd1, 5'd1, F3_SLT, 5'd0, OPC_BRANCH}, 13'h0000, 1'b1, ALL_ZERO);
		add_row({7'h7F, 5'd31, 5'd31, F3_BGE, 5'h1F, OPC_BRANCH},
			{1'b1, 5'd31, 1'b0, 1'b1, 5'd31}, 1'b0, ALL_ZERO);
		add_row({F7_MULDIV, 5'd3, 5'd2, F3_REM, 5'd1, OPC_OP}, {1'b0, 5'd2, 1'b0, 1'b1, 5'd2},
			1'b0, ALL_ZERO);
		add_row({12'h7FF, 5'd1, F3_SLT, 5'd1, OPC_OPIMM}, {1'b1, 5'd1, 1'b0, 1'b1, 5'd1},
			1'b0, ALL_ZERO);
		// store funct3 outside the four widths
		add_row({7'h00, 5'd1, 5'd1, F3_XOR, 5'd0, OPC_STORE}, 13'h0000, 1'b1, ALL_ZERO);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_tbl[i])
			issue_instr(stim_tbl[i].beat,
				stim_tbl[i].has_want ? stim_tbl[i].want : decode_predict(stim_tbl[i].beat));
		wait_all_decoded();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 300 == 150)
				wait_all_decoded();
			beat = random_instr();
			issue_instr(beat, decode_predict(beat));
		end

		wait_all_decoded();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rvdhf_pkg.sv
rtl/rvdhf_decode.sv
rtl/rvdhf_hazard.sv
rtl/rv32_decode_hazard_forward.sv
rtl/rvdhf_checker.sv
test/tb_top.sv
